// File: rtl/sfs_pkg.sv
// sfs_pkg: shared types and constants of the sprite frame sequencer
// configuration struct, register indexes, sequencer states, divider widths
// no dependencies
`timescale 1ns / 1ps

package sfs_pkg;

  // widths of the shared divider operands
  localparam int unsigned DVD_W = 14;
  localparam int unsigned DVS_W = 13;

  // register reset values
  localparam logic [6:0]  SHEET_COLUMNS_RST = 7'd12;
  localparam logic [10:0] CELL_WIDTH_RST    = 11'd64;
  localparam logic [10:0] CELL_HEIGHT_RST   = 11'd64;
  localparam logic [19:0] FRAME_DELAY_RST   = 20'd100000;

  // frame count limit of a clip
  localparam logic [12:0] FRAME_CNT_MAX = 13'd4096;

  typedef enum logic [1:0] {
    REG_SHEET_COLUMNS = 2'd0,
    REG_CELL_WIDTH    = 2'd1,
    REG_CELL_HEIGHT   = 2'd2,
    REG_FRAME_DELAY   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [6:0]  sheet_columns;
    logic [10:0] cell_width;
    logic [10:0] cell_height;
    logic [19:0] frame_delay_us;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ACC_CHK,
    ST_N_MUL,
    ST_N_SUM,
    ST_ADVANCE,
    ST_DIV_ADV,
    ST_IDX,
    ST_DIV_IDX,
    ST_ABS,
    ST_DIV_RC,
    ST_OUT
  } state_e;

endpackage

// File: rtl/sfs_apb_regs.sv
// sfs_apb_regs: configuration registers behind an apb-style port
// uses sfs_pkg for the register indexes and the configuration struct
`timescale 1ns / 1ps

module sfs_apb_regs
  import sfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SHEET_COLUMNS: cfg_d.sheet_columns  = pwdata[6:0];
        REG_CELL_WIDTH:    cfg_d.cell_width     = pwdata[10:0];
        REG_CELL_HEIGHT:   cfg_d.cell_height    = pwdata[10:0];
        REG_FRAME_DELAY:   cfg_d.frame_delay_us = pwdata[19:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sheet_columns  <= SHEET_COLUMNS_RST;
      cfg_q.cell_width     <= CELL_WIDTH_RST;
      cfg_q.cell_height    <= CELL_HEIGHT_RST;
      cfg_q.frame_delay_us <= FRAME_DELAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_SHEET_COLUMNS: prdata = {25'd0, cfg_q.sheet_columns};
      REG_CELL_WIDTH:    prdata = {21'd0, cfg_q.cell_width};
      REG_CELL_HEIGHT:   prdata = {21'd0, cfg_q.cell_height};
      REG_FRAME_DELAY:   prdata = {12'd0, cfg_q.frame_delay_us};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/sfs_divider.sv
// sfs_divider: restoring divider, one quotient bit per cycle
// shared by the frame wrap, frame index and cell row/column steps; no dependencies
`timescale 1ns / 1ps

module sfs_divider #(
  parameter int unsigned DW = 14,
  parameter int unsigned VW = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quot_q, quot_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [VW-1:0]    dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  // one trial subtraction per cycle
  assign trial = {rem_q, quot_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? diff[VW-1:0] : trial[VW-1:0];
      quot_d = {quot_q[DW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/sprite_frame_sequencer_top.sv
// sprite_frame_sequencer_top: sequencer, clip state and output register
// uses sfs_pkg, sfs_apb_regs and sfs_divider
`timescale 1ns / 1ps

// Steps a sprite-sheet animation. One input channel (valid/stall) carries
// select items (func 1: load a clip unless the same id is already playing)
// and tick items (func 0: add elapsed microseconds, advance a frame once the
// delay is reached). Every item gives one result on the output channel: the
// displayed cell, its pixel origin, the frame number and the done flag.
// Configuration registers sit behind the apb-style port at 0x0..0xc.
// An item runs through seven fixed states (update, delay check, two frame
// count states, step, index, cell address), one pass of the shared
// restoring divider for the cell row/column (14 quotient bits) and the
// output load. A loop wrap past the count, or a frame counter outside the
// clip (registers changed mid clip), adds one more divider pass for the
// frame; both never fall on the same item. One item is in work at a time;
// in_stall_o is high from the transfer until the result is loaded into the
// output register.
// The output register holds a result while out_stall_i is high; the next item
// may already be taken and runs until its own result is due.
// Reset clears the clip state (no clip active, loop on) and loads the
// register reset values.

module sprite_frame_sequencer_top
  import sfs_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned MAX_ROWS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [19:0] elapsed_us_i,
  input  logic [7:0]  clip_id_i,
  input  logic [5:0]  first_row_i,
  input  logic [5:0]  first_col_i,
  input  logic [5:0]  last_row_i,
  input  logic [5:0]  last_col_i,
  input  logic        loop_on_i,
  input  logic        bounce_on_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        rect_updated_o,
  output logic [11:0] frame_number_o,
  output logic [5:0]  cell_row_o,
  output logic [5:0]  cell_col_o,
  output logic [15:0] pixel_left_o,
  output logic [15:0] pixel_top_o,
  output logic        clip_done_o
);

  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned TPW = RW + 11;
  localparam logic [DVD_W-1:0] ROW_MAX = DVD_W'(MAX_ROWS - 1);
  localparam logic [8:0]       COL_MAX = 9'(MAX_COLUMNS);

  cfg_t   cfg;
  state_e state_q, state_d;

  // captured item
  logic        func_q;
  logic [19:0] elapsed_q;
  logic [7:0]  id_in_q;
  logic [5:0]  fr_in_q, fc_in_q, lr_in_q, lc_in_q;
  logic        loop_in_q, bounce_in_q;

  // clip state
  logic        clip_active_q;
  logic [7:0]  current_id_q;
  logic [5:0]  first_row_q, first_col_q, last_row_q, last_col_q;
  logic        loop_flag_q, bounce_flag_q, moving_fwd_q;
  logic [11:0] frame_cnt_q;
  logic [31:0] acc_q;

  // per-item working registers
  logic              upd_q, adv_q;
  logic signed [14:0] prod_q;
  logic [12:0]       n_q;
  logic [11:0]       idx_q;
  logic [RW-1:0]     row_q;
  logic [6:0]        col_q;

  // output register
  logic        out_valid_q;
  logic        o_upd_q, o_done_q;
  logic [11:0] o_frame_q;
  logic [5:0]  o_row_q, o_col_q;
  logic [15:0] o_left_q, o_top_q;

  // divider hookup
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs, div_rem;

  // combinational helpers
  logic [6:0]          c_eff;
  logic [32:0]         acc_sum;
  logic signed [6:0]   row_diff;
  logic signed [15:0]  n_sum;
  logic [12:0]         f_inc;
  logic [13:0]         abs_idx;
  logic [DVD_W-1:0]    row_clamp;
  logic [17:0]         left_prod;
  logic [TPW-1:0]      top_prod;
  logic [RW+5:0]       row_ext;
  logic                out_free;
  logic                done_calc;

  sfs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfs_divider #(
    .DW (DVD_W),
    .VW (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // effective column count, clamped to 1..MAX_COLUMNS
  always_comb begin
    c_eff = cfg.sheet_columns;
    if (c_eff == 7'd0) begin
      c_eff = 7'd1;
    end else if ({2'b00, cfg.sheet_columns} > COL_MAX) begin
      c_eff = COL_MAX[6:0];
    end
  end

  // datapath helpers
  assign acc_sum   = {1'b0, acc_q} + {13'd0, elapsed_q};
  assign row_diff  = signed'({1'b0, last_row_q}) - signed'({1'b0, first_row_q});
  assign n_sum     = 16'(prod_q) + signed'({10'd0, last_col_q})
                     - signed'({10'd0, first_col_q}) + 16'sd1;
  assign f_inc     = {1'b0, frame_cnt_q} + 13'd1;
  assign abs_idx   = 14'(first_row_q) * 14'(c_eff) + 14'(first_col_q) + 14'(idx_q);
  assign row_clamp = (div_quot > ROW_MAX) ? ROW_MAX : div_quot;
  assign left_prod = 18'(col_q) * 18'(cfg.cell_width);
  assign top_prod  = TPW'(row_q) * TPW'(cfg.cell_height);
  assign row_ext   = (RW + 6)'(row_q);
  assign out_free  = !(out_valid_q && out_stall_i);
  assign done_calc = loop_flag_q ? 1'b0 :
                     !clip_active_q ? 1'b1 :
                     ({1'b0, frame_cnt_q} >= (n_q - 13'd1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_UPDATE;
      ST_UPDATE:  state_d = ST_ACC_CHK;
      ST_ACC_CHK: state_d = ST_N_MUL;
      ST_N_MUL:   state_d = ST_N_SUM;
      ST_N_SUM:   state_d = ST_ADVANCE;
      ST_ADVANCE: begin
        if (adv_q && !bounce_flag_q && loop_flag_q && (f_inc >= n_q)) begin
          state_d = ST_DIV_ADV;
        end else begin
          state_d = ST_IDX;
        end
      end
      ST_DIV_ADV: if (div_done) state_d = ST_IDX;
      ST_IDX: begin
        if ({1'b0, frame_cnt_q} < n_q) state_d = ST_ABS;
        else state_d = ST_DIV_IDX;
      end
      ST_DIV_IDX: if (div_done) state_d = ST_ABS;
      ST_ABS:     state_d = ST_DIV_RC;
      ST_DIV_RC:  if (div_done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: stall and divider requests
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    div_dvd    = DVD_W'(frame_cnt_q);
    div_dvs    = n_q;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_ADVANCE: begin
        div_dvd   = DVD_W'(f_inc);
        div_start = adv_q && !bounce_flag_q && loop_flag_q && (f_inc >= n_q);
      end
      ST_IDX: begin
        div_start = ({1'b0, frame_cnt_q} >= n_q);
      end
      ST_ABS: begin
        div_dvd   = abs_idx;
        div_dvs   = DVS_W'(c_eff);
        div_start = 1'b1;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      func_q      <= func_i;
      elapsed_q   <= elapsed_us_i;
      id_in_q     <= clip_id_i;
      fr_in_q     <= first_row_i;
      fc_in_q     <= first_col_i;
      lr_in_q     <= last_row_i;
      lc_in_q     <= last_col_i;
      loop_in_q   <= loop_on_i;
      bounce_in_q <= bounce_on_i;
    end
  end

  // clip state and frame stepping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_active_q <= 1'b0;
      current_id_q  <= '0;
      first_row_q   <= '0;
      first_col_q   <= '0;
      last_row_q    <= '0;
      last_col_q    <= '0;
      loop_flag_q   <= 1'b1;
      bounce_flag_q <= 1'b0;
      moving_fwd_q  <= 1'b1;
      frame_cnt_q   <= '0;
      acc_q         <= '0;
      upd_q         <= 1'b0;
      adv_q         <= 1'b0;
    end else begin
      unique case (state_q)
        ST_UPDATE: begin
          upd_q <= 1'b0;
          adv_q <= 1'b0;
          if (func_q) begin
            if (!clip_active_q || id_in_q != current_id_q) begin
              clip_active_q <= 1'b1;
              current_id_q  <= id_in_q;
              first_row_q   <= fr_in_q;
              first_col_q   <= fc_in_q;
              last_row_q    <= lr_in_q;
              last_col_q    <= lc_in_q;
              loop_flag_q   <= loop_in_q;
              bounce_flag_q <= bounce_in_q;
              moving_fwd_q  <= 1'b1;
              frame_cnt_q   <= '0;
              acc_q         <= '0;
              upd_q         <= 1'b1;
            end
          end else if (clip_active_q) begin
            // saturating accumulate
            acc_q <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
          end
        end
        ST_ACC_CHK: begin
          if (!func_q && clip_active_q && acc_q >= {12'd0, cfg.frame_delay_us}) begin
            acc_q <= acc_q - {12'd0, cfg.frame_delay_us};
            adv_q <= 1'b1;
            upd_q <= 1'b1;
          end
        end
        ST_ADVANCE: begin
          if (adv_q) begin
            if (bounce_flag_q) begin
              // ping-pong
              if (n_q == 13'd1) begin
                frame_cnt_q  <= '0;
                moving_fwd_q <= 1'b1;
              end else if (moving_fwd_q) begin
                if (f_inc >= n_q) begin
                  frame_cnt_q  <= 12'(n_q - 13'd2);
                  moving_fwd_q <= 1'b0;
                end else begin
                  frame_cnt_q <= f_inc[11:0];
                end
              end else if (frame_cnt_q == 12'd0) begin
                frame_cnt_q  <= 12'd1;
                moving_fwd_q <= 1'b1;
              end else if ({1'b0, frame_cnt_q} > n_q) begin
                // a step back that still lands past the clip turns at the end
                frame_cnt_q  <= 12'(n_q - 13'd2);
                moving_fwd_q <= 1'b0;
              end else begin
                frame_cnt_q <= frame_cnt_q - 12'd1;
              end
            end else if (loop_flag_q) begin
              // wrap past the count goes through the divider
              if (f_inc < n_q) frame_cnt_q <= f_inc[11:0];
            end else if ({1'b0, frame_cnt_q} < (n_q - 13'd1)) begin
              frame_cnt_q <= f_inc[11:0];
            end
          end
        end
        ST_DIV_ADV: begin
          if (div_done) frame_cnt_q <= div_rem[11:0];
        end
        default: begin
          upd_q <= upd_q;
        end
      endcase
    end
  end

  // frame count, index and cell working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_N_MUL: prod_q <= row_diff * signed'({1'b0, c_eff});
      ST_N_SUM: begin
        if (n_sum < 16'sd1) n_q <= 13'd1;
        else if (n_sum > signed'({3'b000, FRAME_CNT_MAX})) n_q <= FRAME_CNT_MAX;
        else n_q <= n_sum[12:0];
      end
      ST_IDX: begin
        if ({1'b0, frame_cnt_q} < n_q) idx_q <= frame_cnt_q;
      end
      ST_DIV_IDX: begin
        if (div_done) idx_q <= div_rem[11:0];
      end
      ST_DIV_RC: begin
        if (div_done) begin
          row_q <= row_clamp[RW-1:0];
          col_q <= div_rem[6:0];
        end
      end
      default: idx_q <= idx_q;
    endcase
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      o_upd_q   <= upd_q;
      o_done_q  <= done_calc;
      o_frame_q <= clip_active_q ? frame_cnt_q : 12'd0;
      o_row_q   <= clip_active_q ? row_ext[5:0] : 6'd0;
      o_col_q   <= clip_active_q ? col_q[5:0] : 6'd0;
      if (!clip_active_q) begin
        o_left_q <= 16'd0;
        o_top_q  <= 16'd0;
      end else begin
        o_left_q <= (32'(left_prod) > 32'd65535) ? 16'hFFFF : left_prod[15:0];
        o_top_q  <= (32'(top_prod) > 32'd65535) ? 16'hFFFF : 16'(top_prod);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rect_updated_o = o_upd_q;
  assign frame_number_o = o_frame_q;
  assign cell_row_o     = o_row_q;
  assign cell_col_o     = o_col_q;
  assign pixel_left_o   = o_left_q;
  assign pixel_top_o    = o_top_q;
  assign clip_done_o    = o_done_q;

`ifndef SYNTHESIS
  // the divider is never busy while the block waits for an item
  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !div_busy)
    else $error("divider busy while idle");

  // a transfer in always starts the sequence
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready right after a transfer in");

  // an updated cell implies a clip has been loaded
  a_upd_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rect_updated_o) |-> clip_active_q)
    else $error("rect update without an active clip");
`endif

endmodule
